FILE: rtl/mdb_pkg.sv
// ----------------------------------------------------------------------------
// mdb_pkg
// Shared types and constants of the multichannel input debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package mdb_pkg;

    // channel storage
    localparam int CHANNELS = 8;
    localparam int CH_W     = 3;
    localparam int TIME_W   = 32;
    localparam int RUN_W    = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_TICKS  = 3'd4;

    // configuration reset values
    localparam logic [RUN_W-1:0]  STABLE_SAMPLES_RST = 4'd3;
    localparam logic [TIME_W-1:0] REFRESH_TICKS_RST  = 32'd10000;

    // per-channel state word kept in the state memory
    typedef struct packed {
        logic              candidate_value;
        logic [RUN_W-1:0]  run_length;
        logic              stable_value;
        logic              has_reported;
        logic [TIME_W-1:0] last_report_time;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

endpackage

`default_nettype wire

FILE: rtl/mdb_sample_if.sv
// ----------------------------------------------------------------------------
// mdb_sample_if
// Sample request channel: channel index, raw pin level and tick timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdb_sample_if;

    logic                        valid;
    logic                        ready;
    logic [mdb_pkg::CH_W-1:0]    sample_channel;
    logic                        raw_level;
    logic [mdb_pkg::TIME_W-1:0]  sample_time;

    modport source (output valid, output sample_channel, output raw_level,
                    output sample_time, input ready);
    modport sink   (input valid, input sample_channel, input raw_level,
                    input sample_time, output ready);

endinterface

`default_nettype wire

FILE: rtl/mdb_report_if.sv
// ----------------------------------------------------------------------------
// mdb_report_if
// Report request channel: channel index and its debounced value.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdb_report_if;

    logic                     valid;
    logic                     ready;
    logic [mdb_pkg::CH_W-1:0] report_channel;
    logic                     report_value;

    modport source (output valid, output report_channel, output report_value,
                    input ready);
    modport sink   (input valid, input report_channel, input report_value,
                    output ready);

endinterface

`default_nettype wire

FILE: rtl/mdb_cfg_if.sv
// ----------------------------------------------------------------------------
// mdb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdb_cfg_if;

    logic                            valid;
    logic                            ready;
    logic [mdb_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [mdb_pkg::TIME_W-1:0]      wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);

endinterface

`default_nettype wire

FILE: rtl/mdb_ram.sv
// ----------------------------------------------------------------------------
// mdb_ram
// Generic single-clock RAM, one write port and one read port with
// registered read data; a read at the address being written returns old data.
// ----------------------------------------------------------------------------
`default_nettype none

module mdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/multichannel_input_debounce_report.sv
// ----------------------------------------------------------------------------
// multichannel_input_debounce_report
// Per-channel input debouncer that reports stable values and refreshes them.
// ----------------------------------------------------------------------------
// Channels: sample (sink) takes one pin sample per request; report (source)
// gives zero or one report per sample, in sample order; cfg (sink) writes the
// five configuration registers and is always ready. Write cfg only while idle.
// Per-channel state lives in a small synchronous RAM. A sample is accepted
// and its channel entry read; in the update stage the entry is updated, written
// back and any report loaded into the output register. A back-to-back sample
// of the same channel takes the just-written entry from a bypass register.
// A report passes through the update stage, then the output register.
// Throughput: one sample per cycle unless a reporting sample stalls, set by
// the single read-modify-write of the state RAM.
// Reset: control and configuration registers reset and every channel entry
// reads as zero through per-entry valid flags; no clearing pass is needed.
// Stall: while a report waits, later samples still go through; a sample
// that must report stalls in the update stage and holds sample.ready low
// until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_input_debounce_report (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mdb_sample_if.sink    sample,
    mdb_report_if.source  report,
    mdb_cfg_if.sink       cfg
);

    // configuration registers
    logic [3:0]                    channel_count_reg;
    logic [mdb_pkg::CHANNELS-1:0]  input_enable_reg;
    logic [mdb_pkg::CHANNELS-1:0]  active_low_reg;
    logic [mdb_pkg::RUN_W-1:0]     stable_samples_reg;
    logic [mdb_pkg::TIME_W-1:0]    refresh_ticks_reg;

    // update stage
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [mdb_pkg::CH_W-1:0]      s1_ch_reg;
    logic                          s1_level_reg;
    logic [mdb_pkg::TIME_W-1:0]    s1_time_reg;
    logic                          s1_ent_valid_reg;

    // entry valid flags and write bypass
    logic [mdb_pkg::CHANNELS-1:0]  entry_valid_reg;
    logic                          fwd_valid_reg;
    logic [mdb_pkg::CH_W-1:0]      fwd_ch_reg;
    mdb_pkg::chan_state_t          fwd_data_reg;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [mdb_pkg::CH_W-1:0]      out_ch_reg;
    logic                          out_value_reg;

    logic                          sample_accept;
    logic                          cfg_accept;
    logic [mdb_pkg::STATE_W-1:0]   ram_rdata;
    mdb_pkg::chan_state_t          cur;
    mdb_pkg::chan_state_t          upd;
    logic                          s1_enabled;
    logic                          s1_level;
    logic [mdb_pkg::RUN_W-1:0]     need;
    logic [mdb_pkg::TIME_W-1:0]    elapsed;
    logic                          s1_report;
    logic                          out_free;
    logic                          s1_go;
    logic                          ram_we;

    assign cfg.ready     = 1'b1;
    assign cfg_accept    = cfg.valid & cfg.ready;
    assign sample_accept = sample.valid & sample.ready;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg  <= '0;
            input_enable_reg   <= '0;
            active_low_reg     <= '0;
            stable_samples_reg <= mdb_pkg::STABLE_SAMPLES_RST;
            refresh_ticks_reg  <= mdb_pkg::REFRESH_TICKS_RST;
        end
        else if (cfg_accept)
        begin
            unique case (cfg.reg_index)
                mdb_pkg::REG_CHANNEL_COUNT:  channel_count_reg  <= cfg.wdata[3:0];
                mdb_pkg::REG_INPUT_ENABLE:   input_enable_reg   <= cfg.wdata[7:0];
                mdb_pkg::REG_ACTIVE_LOW:     active_low_reg     <= cfg.wdata[7:0];
                mdb_pkg::REG_STABLE_SAMPLES: stable_samples_reg <= cfg.wdata[3:0];
                mdb_pkg::REG_REFRESH_TICKS:  refresh_ticks_reg  <= cfg.wdata;
                default: ;
            endcase
        end
    end

    // channel state memory
    mdb_ram #(
        .WIDTH (mdb_pkg::STATE_W),
        .DEPTH (mdb_pkg::CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_ch_reg),
        .wdata (upd),
        .re    (sample_accept),
        .raddr (sample.sample_channel),
        .rdata (ram_rdata)
    );

    // current entry: bypass, then stored word, else the reset value
    always_comb
    begin
        priority if (fwd_valid_reg && (fwd_ch_reg == s1_ch_reg))
        begin
            cur = fwd_data_reg;
        end
        else if (s1_ent_valid_reg)
        begin
            cur = mdb_pkg::chan_state_t'(ram_rdata);
        end
        else
        begin
            cur = '0;
        end
    end

    // sample filter and logical level
    assign s1_enabled = (32'(s1_ch_reg) < mdb_pkg::CHANNELS)
                      && ({1'b0, s1_ch_reg} < channel_count_reg)
                      && input_enable_reg[s1_ch_reg];
    assign s1_level   = s1_level_reg ^ active_low_reg[s1_ch_reg];
    assign need       = (stable_samples_reg == '0) ? 4'd1 : stable_samples_reg;

    // run update and report decision
    always_comb
    begin
        upd = cur;
        if (s1_level != cur.candidate_value)
        begin
            upd.candidate_value = s1_level;
            upd.run_length      = 4'd1;
        end
        else if (cur.run_length < need)
        begin
            upd.run_length = cur.run_length + 4'd1;
        end
        elapsed   = s1_time_reg - cur.last_report_time;
        s1_report = s1_enabled && (upd.run_length >= need)
                 && (!cur.has_reported || (cur.stable_value != upd.candidate_value)
                     || (elapsed >= refresh_ticks_reg));
        if (s1_report)
        begin
            upd.has_reported     = 1'b1;
            upd.stable_value     = upd.candidate_value;
            upd.last_report_time = s1_time_reg;
        end
    end

    // stage flow control
    assign out_free     = !out_valid_reg || report.ready;
    assign s1_go        = s1_valid_reg && (!s1_report || out_free);
    assign sample.ready = !s1_valid_reg || s1_go;
    assign ram_we       = s1_go && s1_enabled;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (sample_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_report)
        begin
            out_valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                entry_valid_reg[s1_ch_reg] <= 1'b1;
                fwd_valid_reg              <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_ch_reg        <= sample.sample_channel;
            s1_level_reg     <= sample.raw_level;
            s1_time_reg      <= sample.sample_time;
            s1_ent_valid_reg <= entry_valid_reg[sample.sample_channel];
        end
        if (ram_we)
        begin
            fwd_ch_reg   <= s1_ch_reg;
            fwd_data_reg <= upd;
        end
        if (s1_go && s1_report)
        begin
            out_ch_reg    <= s1_ch_reg;
            out_value_reg <= upd.stable_value;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.report_channel = out_ch_reg;
    assign report.report_value   = out_value_reg;

endmodule

`default_nettype wire
